FILE: rtl/tbsp_pkg.sv
// Shared types and constants for the timed blink sequence player.
// Used by tbsp_ctrl, tbsp_dp and timed_blink_sequence_player.
`timescale 1ns / 1ps
package tbsp_pkg;

    localparam int CHANNELS    = 4;
    localparam int TABLE_DEPTH = 16;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam int CH_W        = $clog2(CHANNELS);
    localparam int LEN_W       = 5;
    localparam int TIME_W      = 32;
    localparam int LEVEL_W     = 8;
    localparam int LEN_MIN     = 2;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [TIME_W-1:0]  start_time;
        logic [CH_W-1:0]    channel;
        logic [LEVEL_W-1:0] level;
        logic               start_on;
        logic [TIME_W-1:0]  on_time;
        logic [TIME_W-1:0]  off_time;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic tab_wr;    // write table entry from the input ports
        logic prep;      // range check of position, count one ms
        logic rd_scan;   // read entry at play position
        logic apply;     // apply the entry just read
        logic rd_chan;   // read entry bound to current channel
        logic upd;       // step current channel's phase
        logic load_out;  // capture levels into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic due;       // entry start below elapsed time
        logic last;      // play position is the last entry in use
        logic ch_last;   // current channel is the last one
        logic out_free;  // output register can take a result
    } t_sts;

endpackage

FILE: rtl/tbsp_ctrl.sv
// Sequencer for the timed blink sequence player.
// Depends on tbsp_pkg; drives the command struct of tbsp_dp.
`timescale 1ns / 1ps
module tbsp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_opcode,
    output logic           o_stall,
    input  tbsp_pkg::t_sts i_sts,
    output tbsp_pkg::t_cmd o_cmd
);
    import tbsp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_PREP   = 7'b0000010,
        S_FETCH  = 7'b0000100,
        S_CHECK  = 7'b0001000,
        S_UFETCH = 7'b0010000,
        S_UPD    = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (t_opcode'(i_opcode) == OP_WRITE) begin
                        o_cmd.tab_wr = 1'b1;
                    end else begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.rd_scan = 1'b1;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.due) begin
                    o_cmd.apply = 1'b1;
                    n_state     = i_sts.last ? S_UFETCH : S_FETCH;
                end else begin
                    n_state = S_UFETCH;
                end
            end
            S_UFETCH: begin
                o_cmd.rd_chan = 1'b1;
                n_state       = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.ch_last ? S_OUT : S_UFETCH;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: rtl/tbsp_dp.sv
// Datapath: entry table memory, play state, channel phase state, result register.
// Depends on tbsp_pkg; commanded by tbsp_ctrl.
`timescale 1ns / 1ps
module tbsp_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tbsp_pkg::t_cmd                    i_cmd,
    output tbsp_pkg::t_sts                    o_sts,
    input  logic [tbsp_pkg::TAB_AW-1:0]       i_entry_index,
    input  logic [tbsp_pkg::TIME_W-1:0]       i_start_time,
    input  logic [tbsp_pkg::CH_W-1:0]         i_target_channel,
    input  logic [tbsp_pkg::LEVEL_W-1:0]      i_on_level,
    input  logic                              i_start_on,
    input  logic [tbsp_pkg::TIME_W-1:0]       i_on_duration,
    input  logic [tbsp_pkg::TIME_W-1:0]       i_off_duration,
    input  logic                              i_cfg_wr,
    input  logic [tbsp_pkg::LEN_W-1:0]        i_cfg_data,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [tbsp_pkg::LEVEL_W-1:0]      o_level [tbsp_pkg::CHANNELS],
    output logic [tbsp_pkg::TAB_AW-1:0]       o_position
);
    import tbsp_pkg::*;

    // entry table
    t_entry             r_tab [TABLE_DEPTH];
    t_entry             r_rd;
    logic [TAB_AW-1:0]  rd_addr;

    // play state
    logic [LEN_W-1:0]   r_table_length;
    logic [TIME_W-1:0]  r_elapsed;
    logic [TAB_AW-1:0]  r_next;
    logic [CH_W-1:0]    r_ch;

    // channel state
    logic               r_bound   [CHANNELS];
    logic [TAB_AW-1:0]  r_centry  [CHANNELS];
    logic               r_phase   [CHANNELS];
    logic [TIME_W-1:0]  r_cnt     [CHANNELS];
    logic [LEVEL_W-1:0] r_level   [CHANNELS];

    // result register
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_level [CHANNELS];
    logic [TAB_AW-1:0]  r_out_pos;

    logic [LEN_W-1:0]   len;
    logic               pos_bad;
    logic [TIME_W-1:0]  cnt_inc;
    logic [TIME_W-1:0]  cnt_lim;
    logic [CHANNELS-1:0] lit_unbound;

    // effective length, saturated to 2..TABLE_DEPTH
    always_comb begin
        if (r_table_length < LEN_W'(LEN_MIN)) begin
            len = LEN_W'(LEN_MIN);
        end else if (r_table_length > LEN_W'(TABLE_DEPTH)) begin
            len = LEN_W'(TABLE_DEPTH);
        end else begin
            len = r_table_length;
        end
    end

    assign pos_bad = ({1'b0, r_next} >= len) || (r_next == '0);
    assign rd_addr = i_cmd.rd_chan ? r_centry[r_ch] : r_next;
    assign cnt_inc = r_cnt[r_ch] + TIME_W'(1);
    assign cnt_lim = r_phase[r_ch] ? r_rd.on_time : r_rd.off_time;

    assign o_sts.due      = (r_rd.start_time < r_elapsed);
    assign o_sts.last     = ({1'b0, r_next} == (len - LEN_W'(1)));
    assign o_sts.ch_last  = (r_ch == CH_W'(CHANNELS - 1));
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.tab_wr) begin
            r_tab[i_entry_index] <= '{start_time: i_start_time,
                                      channel:    i_target_channel,
                                      level:      i_on_level,
                                      start_on:   i_start_on,
                                      on_time:    i_on_duration,
                                      off_time:   i_off_duration};
        end
        if (i_cmd.rd_scan || i_cmd.rd_chan) begin
            r_rd <= r_tab[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= LEN_W'(LEN_MIN);
            r_elapsed      <= '0;
            r_next         <= TAB_AW'(1);
            r_ch           <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_table_length <= i_cfg_data;
            end
            if (i_cmd.prep) begin
                r_ch <= '0;
                if (pos_bad) begin
                    r_next    <= TAB_AW'(1);
                    r_elapsed <= TIME_W'(1);
                end else begin
                    r_elapsed <= r_elapsed + TIME_W'(1);
                end
            end
            if (i_cmd.apply) begin
                if (o_sts.last) begin
                    r_next    <= TAB_AW'(1);
                    r_elapsed <= '0;
                end else begin
                    r_next <= r_next + TAB_AW'(1);
                end
            end
            if (i_cmd.upd) begin
                r_ch <= r_ch + CH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_bound[c]  <= 1'b0;
                r_centry[c] <= '0;
                r_phase[c]  <= 1'b0;
                r_cnt[c]    <= '0;
                r_level[c]  <= '0;
            end
        end else if (i_cmd.apply) begin
            r_bound[r_rd.channel]  <= 1'b1;
            r_centry[r_rd.channel] <= r_next;
            r_cnt[r_rd.channel]    <= '0;
            r_phase[r_rd.channel]  <= r_rd.start_on;
            r_level[r_rd.channel]  <= r_rd.start_on ? r_rd.level : '0;
        end else if (i_cmd.upd && r_bound[r_ch]) begin
            if (cnt_inc > cnt_lim) begin
                r_cnt[r_ch]   <= '0;
                r_phase[r_ch] <= !r_phase[r_ch];
                r_level[r_ch] <= r_phase[r_ch] ? '0 : r_rd.level;
            end else begin
                r_cnt[r_ch] <= cnt_inc;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_level <= r_level;
            r_out_pos   <= r_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level     = r_out_level;
    assign o_position  = r_out_pos;

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            lit_unbound[c] = !r_bound[c] && (r_level[c] != '0);
        end
    end

    // assertions
    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next != '0)
        else $error("play position reached the header entry");

    a_dark_unbound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lit_unbound == '0)
        else $error("unbound channel is lit");

    a_wrap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.apply && o_sts.last |=> (r_elapsed == '0) && (r_next == TAB_AW'(1)))
        else $error("loop wrap did not restart time and position");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> $stable(r_out_pos) && r_out_valid)
        else $error("pending result overwritten");

endmodule

FILE: rtl/timed_blink_sequence_player.sv
// Top level of the timed blink sequence player.
// Depends on tbsp_pkg, tbsp_ctrl and tbsp_dp.
`timescale 1ns / 1ps
// Usage
//   Input channel (i_valid / o_stall): one request per item. opcode OP_WRITE
//   loads table entry i_entry_index in the accept cycle and returns nothing.
//   opcode OP_TICK counts one millisecond, walks the table from the play
//   position applying entries in order while their start time is below
//   elapsed time, then steps the four channel phase counters and returns one result.
//   Output channel (o_valid / i_stall): channel levels and play position.
//   Config channel (i_cfg_valid / o_cfg_ready): table_length, always ready;
//   write it only while no tick is in flight.
// Sequence
//   A tick runs a prepare step, a table scan that ends at the first entry
//   not yet due or after applying the last entry in use, a pass over all
//   channels and an output step: each table or channel step is one read
//   of the entry memory followed by one evaluate step.
//   o_stall is high from acceptance of a tick until its result is stored.
//   A result waits in the output register while i_stall is high; writes
//   are still taken, and a further tick finishes its work and then holds
//   in its final step until the register frees.
// Reset (synchronous, i_rst_n low): time 0, position 1, all channels
//   unbound and dark, table_length 2. Table contents are not cleared.
module timed_blink_sequence_player (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_opcode,
    input  logic [tbsp_pkg::TAB_AW-1:0]       i_entry_index,
    input  logic [tbsp_pkg::TIME_W-1:0]       i_start_time,
    input  logic [tbsp_pkg::CH_W-1:0]         i_target_channel,
    input  logic [tbsp_pkg::LEVEL_W-1:0]      i_on_level,
    input  logic                              i_start_on,
    input  logic [tbsp_pkg::TIME_W-1:0]       i_on_duration,
    input  logic [tbsp_pkg::TIME_W-1:0]       i_off_duration,
    // config channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tbsp_pkg::LEN_W-1:0]        i_cfg_data,
    // output channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [tbsp_pkg::LEVEL_W-1:0]      o_level_ch0,
    output logic [tbsp_pkg::LEVEL_W-1:0]      o_level_ch1,
    output logic [tbsp_pkg::LEVEL_W-1:0]      o_level_ch2,
    output logic [tbsp_pkg::LEVEL_W-1:0]      o_level_ch3,
    output logic [tbsp_pkg::TAB_AW-1:0]       o_play_position
);
    import tbsp_pkg::*;

    t_cmd               cmd;
    t_sts               sts;
    logic [LEVEL_W-1:0] level [CHANNELS];

    // register is always writable
    assign o_cfg_ready = 1'b1;

    tbsp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .o_stall  (o_stall),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    tbsp_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_entry_index    (i_entry_index),
        .i_start_time     (i_start_time),
        .i_target_channel (i_target_channel),
        .i_on_level       (i_on_level),
        .i_start_on       (i_start_on),
        .i_on_duration    (i_on_duration),
        .i_off_duration   (i_off_duration),
        .i_cfg_wr         (i_cfg_valid && o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_out_stall      (i_stall),
        .o_out_valid      (o_valid),
        .o_level          (level),
        .o_position       (o_play_position)
    );

    // fixed four level ports
    assign o_level_ch0 = level[0];
    assign o_level_ch1 = level[1];
    assign o_level_ch2 = level[2];
    assign o_level_ch3 = level[3];

endmodule
